>>> rtl/bfr_pkg.sv
// Shared types and codes for the bus frame receiver.
// No dependencies; every other file in rtl refers to it by scoped names.
package bfr_pkg;

    // Configuration port geometry: one 32-bit register per word.
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [0:0]  REG_IDX_MIN_LEN = 1'd0;
    localparam logic [7:0]  MIN_LEN_RESET   = 8'd3;

    // Input item modes
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Result item kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Frame status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADSUM = 2'd1;
    localparam logic [1:0] ST_SHORT  = 2'd2;
    localparam logic [1:0] ST_ABORT  = 2'd3;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } bfr_in_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic [1:0] frame_status;
        logic [7:0] frame_flags;
        logic [7:0] frame_address;
        logic [7:0] frame_length;
    } bfr_out_t;

    // Result of one step of the deframer
    typedef struct packed {
        logic     valid;
        bfr_out_t data;
    } bfr_result_t;

endpackage

>>> rtl/bfr_cfg_regs.sv
// APB-style configuration register block for the bus frame receiver.
// Holds the minimum payload length; depends on bfr_pkg.
module bfr_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bfr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bfr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bfr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [7:0]                      min_len
);

    logic [7:0] min_len_reg;
    logic [7:0] min_len_next;
    logic       hit_min_len;
    logic       wr_en;

    assign pready      = 1'b1;
    assign hit_min_len = (paddr[bfr_pkg::APB_ADDR_W-1:2] == bfr_pkg::REG_IDX_MIN_LEN);
    assign wr_en       = psel && penable && pwrite;

    always_comb begin
        min_len_next = min_len_reg;
        if (wr_en && hit_min_len) begin
            min_len_next = pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= bfr_pkg::MIN_LEN_RESET;
        end else begin
            min_len_reg <= min_len_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (hit_min_len) begin
            prdata = {{(bfr_pkg::APB_DATA_W-8){1'b0}}, min_len_reg};
        end
    end

    assign min_len = min_len_reg;

endmodule

>>> rtl/bfr_deframer.sv
// Frame state tracker and per-item result logic of the bus frame receiver.
// Depends on bfr_pkg for item types and status codes.
module bfr_deframer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  bfr_pkg::bfr_in_t     item,
    input  logic [7:0]           min_len,
    output bfr_pkg::bfr_result_t result
);

    localparam logic [1:0] PH_FLAGS   = 2'd0;
    localparam logic [1:0] PH_ADDRESS = 2'd1;
    localparam logic [1:0] PH_LENGTH  = 2'd2;
    localparam logic [1:0] PH_BODY    = 2'd3;

    logic [1:0] phase_reg,   phase_next;
    logic [7:0] sum_reg,     sum_next;
    logic [7:0] flags_reg,   flags_next;
    logic [7:0] address_reg, address_next;
    logic [7:0] length_reg,  length_next;
    logic [7:0] count_reg,   count_next;
    logic       active_reg,  active_next;
    logic [7:0] sum_plus;

    assign sum_plus = sum_reg + item.rx_byte;

    always_comb begin
        phase_next   = phase_reg;
        sum_next     = sum_reg;
        flags_next   = flags_reg;
        address_next = address_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        active_next  = active_reg;

        result                    = '0;
        result.data.frame_flags   = flags_reg;
        result.data.frame_address = address_reg;
        result.data.frame_length  = length_reg;

        if (item.mode == bfr_pkg::MODE_TICK) begin
            if (active_reg) begin
                active_next = 1'b0;
            end else if (phase_reg != PH_FLAGS) begin
                // idle line mid-frame: abort and resync
                result.valid             = 1'b1;
                result.data.kind         = bfr_pkg::KIND_VERDICT;
                result.data.frame_status = bfr_pkg::ST_ABORT;
                phase_next               = PH_FLAGS;
            end
        end else begin
            active_next = 1'b1;
            unique case (phase_reg)
                PH_FLAGS: begin
                    flags_next   = item.rx_byte;
                    address_next = '0;
                    length_next  = '0;
                    count_next   = '0;
                    sum_next     = item.rx_byte;
                    phase_next   = PH_ADDRESS;
                end
                PH_ADDRESS: begin
                    address_next = item.rx_byte;
                    sum_next     = sum_plus;
                    phase_next   = PH_LENGTH;
                end
                PH_LENGTH: begin
                    length_next = item.rx_byte;
                    sum_next    = sum_plus;
                    count_next  = '0;
                    phase_next  = PH_BODY;
                end
                default: begin
                    if (count_reg < length_reg) begin
                        result.valid             = 1'b1;
                        result.data.kind         = bfr_pkg::KIND_PAYLOAD;
                        result.data.payload_byte = item.rx_byte;
                        result.data.byte_index   = count_reg;
                        result.data.frame_status = bfr_pkg::ST_OK;
                        sum_next                 = sum_plus;
                        count_next               = count_reg + 8'd1;
                    end else begin
                        // checksum byte: bad sum wins over too short
                        result.valid     = 1'b1;
                        result.data.kind = bfr_pkg::KIND_VERDICT;
                        if (item.rx_byte != sum_reg) begin
                            result.data.frame_status = bfr_pkg::ST_BADSUM;
                        end else if (length_reg < min_len) begin
                            result.data.frame_status = bfr_pkg::ST_SHORT;
                        end else begin
                            result.data.frame_status = bfr_pkg::ST_OK;
                        end
                        phase_next = PH_FLAGS;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FLAGS;
            sum_reg     <= '0;
            flags_reg   <= '0;
            address_reg <= '0;
            length_reg  <= '0;
            count_reg   <= '0;
            active_reg  <= 1'b0;
        end else if (step) begin
            phase_reg   <= phase_next;
            sum_reg     <= sum_next;
            flags_reg   <= flags_next;
            address_reg <= address_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            active_reg  <= active_next;
        end
    end

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (count_reg <= length_reg))
        else $error("payload count ran past frame length");

    a_no_result_on_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_FLAGS) |-> !result.valid)
        else $error("result produced while waiting for flags byte");

    a_verdict_resyncs: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && result.valid && (result.data.kind == bfr_pkg::KIND_VERDICT))
        |=> (phase_reg == PH_FLAGS))
        else $error("verdict did not return receiver to flags phase");

    a_byte_marks_activity: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && (item.mode == bfr_pkg::MODE_BYTE)) |=> active_reg)
        else $error("received byte did not mark activity");

endmodule

>>> rtl/bus_frame_receiver.sv
// Top level of the bus frame receiver: config registers, deframer, output register.
// Depends on bfr_pkg, bfr_cfg_regs and bfr_deframer.
//
// Usage: the s_ channel carries one item per handshake, either a received bus
// byte (mode 0) or an inactivity timer tick (mode 1). The m_ channel returns at
// most one result per item: a payload byte with its index, or a frame verdict
// (ok, bad checksum, too short, aborted) with the frame header.
// Latency: a result appears on m_ the cycle after its item is accepted.
// Throughput: one item per cycle unless stalled; frame state updates in the same
// cycle the item is accepted, and a single output register holds the result.
// Stall: while the output register holds an untaken result, s_ready follows
// m_ready, so an item is still taken in the cycle the result leaves.
// Reset (aresetn low, synchronous): the receiver waits for a flags byte, the
// checksum and header are cleared, the output register empties, and
// min_payload_length returns to 3. Write min_payload_length at byte address 0
// only while the block is idle.
module bus_frame_receiver (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  bfr_pkg::bfr_in_t                s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output bfr_pkg::bfr_out_t               m_payload,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bfr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bfr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bfr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    logic                 s_accept;
    logic [7:0]           min_len;
    bfr_pkg::bfr_result_t result;

    logic                 m_valid_reg,   m_valid_next;
    bfr_pkg::bfr_out_t    m_payload_reg, m_payload_next;

    bfr_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .min_len (min_len)
    );

    bfr_deframer u_deframer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (s_accept),
        .item    (s_payload),
        .min_len (min_len),
        .result  (result)
    );

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        if (s_accept) begin
            // output slot is free or draining this cycle
            m_valid_next = result.valid;
            if (result.valid) begin
                m_payload_next = result.data;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

>>> tb/tb.sv
// Self-checking bench for bus_frame_receiver: drives bytes and timer ticks,
// predicts payload and verdict items, and checks them in order.
// Depends on bfr_pkg and the bus_frame_receiver RTL.

class frame_scoreboard;
    typedef enum logic [1:0] {WAIT_FLAGS, WAIT_ADDR, WAIT_LEN, IN_BODY} rx_phase_e;

    logic [7:0]          min_len;
    rx_phase_e           phase;
    logic [7:0]          sum;
    logic [7:0]          hdr_flags;
    logic [7:0]          hdr_addr;
    logic [7:0]          hdr_len;
    logic [7:0]          body_cnt;
    bit                  active;
    bfr_pkg::bfr_out_t   due_results[$];
    int unsigned         mismatches;

    function new();
        min_len    = bfr_pkg::MIN_LEN_RESET;
        phase      = WAIT_FLAGS;
        sum        = '0;
        hdr_flags  = '0;
        hdr_addr   = '0;
        hdr_len    = '0;
        body_cnt   = '0;
        active     = 1'b0;
        mismatches = 0;
    endfunction

    function int pending();
        return due_results.size();
    endfunction

    function void set_min_len(logic [7:0] v);
        min_len = v;
    endfunction

    // Append one expected item at the tail of the queue.
    function void queue_result(bfr_pkg::bfr_out_t r);
        due_results = {due_results, r};
    endfunction

    function bfr_pkg::bfr_out_t make_result(logic kind, logic [7:0] data_v, logic [7:0] idx,
                                            logic [1:0] st);
        bfr_pkg::bfr_out_t r;
        r.kind          = kind;
        r.payload_byte  = data_v;
        r.byte_index    = idx;
        r.frame_status  = st;
        r.frame_flags   = hdr_flags;
        r.frame_address = hdr_addr;
        r.frame_length  = hdr_len;
        return r;
    endfunction

    // Advance the deframer by one accepted item and queue what it produces.
    function void absorb_item(bfr_pkg::bfr_in_t it);
        logic [7:0] b;
        logic [1:0] st;
        b = it.rx_byte;
        if (it.mode == bfr_pkg::MODE_TICK) begin
            if (active) begin
                active = 1'b0;
            end else if (phase != WAIT_FLAGS) begin
                queue_result(make_result(bfr_pkg::KIND_VERDICT, 8'd0, 8'd0,
                                         bfr_pkg::ST_ABORT));
                phase = WAIT_FLAGS;
            end
        end else begin
            active = 1'b1;
            case (phase)
                WAIT_FLAGS: begin
                    hdr_flags = b;
                    hdr_addr  = '0;
                    hdr_len   = '0;
                    body_cnt  = '0;
                    sum       = b;
                    phase     = WAIT_ADDR;
                end
                WAIT_ADDR: begin
                    hdr_addr = b;
                    sum      = sum + b;
                    phase    = WAIT_LEN;
                end
                WAIT_LEN: begin
                    hdr_len  = b;
                    sum      = sum + b;
                    body_cnt = '0;
                    phase    = IN_BODY;
                end
                default: begin
                    if (body_cnt < hdr_len) begin
                        queue_result(make_result(bfr_pkg::KIND_PAYLOAD, b, body_cnt,
                                                 bfr_pkg::ST_OK));
                        sum      = sum + b;
                        body_cnt = body_cnt + 8'd1;
                    end else begin
                        // bad checksum wins over too short
                        if (b != sum)
                            st = bfr_pkg::ST_BADSUM;
                        else if (hdr_len < min_len)
                            st = bfr_pkg::ST_SHORT;
                        else
                            st = bfr_pkg::ST_OK;
                        queue_result(make_result(bfr_pkg::KIND_VERDICT, 8'd0, 8'd0, st));
                        phase = WAIT_FLAGS;
                    end
                end
            endcase
        end
    endfunction

    function string show(bfr_pkg::bfr_out_t r);
        return $sformatf("kind=%0d byte=%02h idx=%0d st=%0d flags=%02h addr=%02h len=%0d",
                         r.kind, r.payload_byte, r.byte_index, r.frame_status,
                         r.frame_flags, r.frame_address, r.frame_length);
    endfunction

    function void match_result(bfr_pkg::bfr_out_t got);
        bfr_pkg::bfr_out_t want;
        if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected item: %s", show(got));
        end else begin
            want = due_results.pop_front();
            if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
                got.byte_index !== want.byte_index || got.frame_status !== want.frame_status ||
                got.frame_flags !== want.frame_flags ||
                got.frame_address !== want.frame_address ||
                got.frame_length !== want.frame_length) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("wrong item: expected %s, got %s", show(want), show(got));
            end
        end
    endfunction
endclass

module tb;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [0:0] REG_IDX_NONE = 1'd1;
    localparam logic [bfr_pkg::APB_ADDR_W-1:0] ADDR_MIN_LEN =
        {bfr_pkg::REG_IDX_MIN_LEN, 2'b00};
    localparam logic [bfr_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED = {REG_IDX_NONE, 2'b00};

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    bfr_pkg::bfr_in_t               s_payload;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    bfr_pkg::bfr_out_t              m_payload;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [bfr_pkg::APB_ADDR_W-1:0] paddr;
    logic [bfr_pkg::APB_DATA_W-1:0] pwdata;
    logic [bfr_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    frame_scoreboard book = new();
    int unsigned     cycles = 0;
    int unsigned     items_sent = 0;
    int unsigned     burst_left = 0;
    int unsigned     stall_cnt = 0;
    int unsigned     stall_span = 64;
    int unsigned     stall_style = 0;

    bus_frame_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                book.absorb_item(s_payload);
            if (m_valid && m_ready)
                book.match_result(m_payload);
        end
    end

    // Receiver back-pressure: pick a new m_ready style when each random span ends.
    always @(negedge aclk) begin
        stall_cnt++;
        if (stall_cnt >= stall_span) begin
            stall_cnt   = 0;
            stall_span  = $urandom_range(32, 256);
            stall_style = $urandom_range(0, 3);
        end
        case (stall_style)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 7) != 0);
            default: m_ready <= ((stall_cnt % 5) < 2);
        endcase
    end

    task automatic push_item(input bfr_pkg::bfr_in_t it);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] v);
        bfr_pkg::bfr_in_t it;
        it.mode    = bfr_pkg::MODE_BYTE;
        it.rx_byte = v;
        push_item(it);
    endtask

    task automatic send_tick();
        bfr_pkg::bfr_in_t it;
        it.mode    = bfr_pkg::MODE_TICK;
        it.rx_byte = 8'($urandom_range(0, 255));
        push_item(it);
    endtask

    task automatic send_frame(input logic [7:0] flags, input logic [7:0] addr,
                              input logic [7:0] len, input bit bad_sum, input bit stray_tick);
        logic [7:0] sum;
        logic [7:0] b;
        sum = flags + addr + len;
        send_byte(flags);
        send_byte(addr);
        send_byte(len);
        for (int i = 0; i < int'(len); i++) begin
            b = 8'($urandom_range(0, 255));
            // a single tick right after a byte only clears the activity flag
            if (stray_tick && i == 0)
                send_tick();
            send_byte(b);
            sum = sum + b;
        end
        send_byte(bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum);
    endtask

    // Hold the sender until every expected item is back, then let the pipe settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (book.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [bfr_pkg::APB_ADDR_W-1:0] addr, input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'd0, v};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_MIN_LEN)
            book.set_min_len(v);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_action();
        int unsigned r;
        int unsigned n;
        logic [7:0]  len;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            if ($urandom_range(0, 199) < 3)
                len = 8'($urandom_range(11, 128));
            else
                len = 8'($urandom_range(0, 10));
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                       $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
        end else if (r < 80) begin
            // cut a frame short and let the idle timer abort it
            n = $urandom_range(1, 6);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(n - 1, 20)));
            repeat (n - 1) send_byte(8'($urandom_range(0, 255)));
            send_tick();
            send_tick();
        end else if (r < 90) begin
            repeat ($urandom_range(1, 3)) send_tick();
        end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            send_tick();
            send_tick();
        end
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned stop;
        stop = items_sent + n;
        while (items_sent < stop) random_action();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset minimum length of three
        send_tick();
        send_frame(8'hFF, 8'h00, 8'd3, 1'b0, 1'b0);
        send_frame(8'h00, 8'hFF, 8'd0, 1'b1, 1'b0);
        send_frame(8'h5A, 8'hA5, 8'd0, 1'b0, 1'b0);
        send_byte(8'h81);
        send_tick();
        send_tick();
        send_byte(8'h7E);
        send_byte(8'h00);
        send_byte(8'd4);
        send_byte(8'hFF);
        send_tick();
        send_tick();
        drain();

        write_reg(ADDR_MIN_LEN, 8'd0);
        run_random(200);
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd255, 1'b0, 1'b0);
        drain();

        write_reg(ADDR_MIN_LEN, 8'd255);
        run_random(150);
        drain();

        write_reg(ADDR_MIN_LEN, 8'($urandom_range(1, 10)));
        run_random(200);
        drain();

        // unmapped register: the write must leave the minimum length alone
        write_reg(ADDR_UNMAPPED, 8'($urandom_range(0, 255)));
        run_random(200);

        drain();
        repeat (8) @(posedge aclk);
        if (book.mismatches == 0 && book.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
